// ----- sv/rlmtf_pkg.sv -----
// Shared constants, types and controller codes for the recency list block.
package rlmtf_pkg;

	localparam int DEPTH = 8;
	localparam int KEY_W = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(5);

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_key;
		logic commit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// ----- sv/rlmtf_ctrl.sv -----
// Controller state machine: captures a word, then commits it once the result slot is free.
module rlmtf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rlmtf_pkg::status_t status,
	output rlmtf_pkg::cmd_t    cmd
);
	import rlmtf_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Advance on accept, return once the result is committed
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_BUSY;
			end
			ST_BUSY: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Drive handshake and commands
	always_comb begin
		in_ready     = 1'b0;
		cmd.load_key = 1'b0;
		cmd.commit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_key = in_valid;
			end
			ST_BUSY: begin
				cmd.commit = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- sv/rlmtf_dp.sv -----
// Datapath: entry registers, parallel key compare, gap-closing shift and result register.
module rlmtf_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	input  rlmtf_pkg::key_t    key,
	input  rlmtf_pkg::cmd_t    cmd,
	output rlmtf_pkg::status_t status,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic               evicted,
	output rlmtf_pkg::key_t    evicted_key,
	output rlmtf_pkg::key_t    most_recent_key,
	output rlmtf_pkg::cnt_t    occupancy
);
	import rlmtf_pkg::*;

	key_t entry_q [DEPTH];
	key_t entry_nxt [DEPTH];
	key_t key_q;
	cnt_t vc_q;
	cnt_t cap_q;
	logic out_valid_q;

	logic hit_c;
	logic evict_c;
	cnt_t rm_pos;
	cnt_t cap_eff;
	cnt_t n_rm;
	cnt_t n_fin;
	logic [DEPTH-1:0] match;

	// Clamp the configured capacity to 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cap_q > CNT_W'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	// Compare every valid entry against the held key
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match[i] = (CNT_W'(i) < vc_q) && (entry_q[i] == key_q);
		end
	end

	// Pick the oldest matching position, else the eviction slot, else none
	always_comb begin
		rm_pos = CNT_W'(DEPTH);
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match[i]) rm_pos = CNT_W'(i);
		end
		hit_c   = |match;
		evict_c = !hit_c && (vc_q >= cap_eff);
		if (evict_c) rm_pos = '0;
		n_rm  = (hit_c || evict_c) ? vc_q - CNT_W'(1) : vc_q;
		n_fin = (n_rm < CNT_W'(DEPTH)) ? n_rm + CNT_W'(1) : n_rm;
	end

	// Close the gap, then append the key as most recent
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (CNT_W'(i) >= rm_pos && i + 1 < DEPTH) begin
				entry_nxt[i] = entry_q[(i + 1) % DEPTH];
			end else begin
				entry_nxt[i] = entry_q[i];
			end
			if (CNT_W'(i) == n_rm) entry_nxt[i] = key_q;
		end
	end

	// Hold entries and key; no reset on payload
	always_ff @(posedge clk) begin
		if (cmd.load_key) key_q <= key;
		if (cmd.commit) begin
			for (int i = 0; i < DEPTH; i++) begin
				entry_q[i] <= entry_nxt[i];
			end
		end
	end

	// Occupancy and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q  <= '0;
			cap_q <= CAP_RESET;
		end else begin
			if (cmd.commit) vc_q <= n_fin;
			if (cfg_we) cap_q <= CNT_W'(cfg_wdata);
		end
	end

	// Result word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit             <= hit_c;
			evicted         <= evict_c;
			evicted_key     <= evict_c ? entry_q[0] : '0;
			most_recent_key <= key_q;
			occupancy       <= n_fin;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || out_ready;

	// Checks
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vc_q <= CNT_W'(DEPTH)) else $error("occupancy beyond depth");
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q) else $error("commit did not raise result valid");
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit && evicted)) else $error("hit and eviction together");
	a_hit_keeps_occ: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && hit_c |=> vc_q == $past(vc_q)) else $error("hit changed occupancy");
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> status.out_free) else $error("commit over a pending result");

endmodule

// ----- sv/recency_list_move_to_front_top.sv -----
// Top level of the recency list: controller and datapath joined by command and status.
// Bounded most-recently-used list of up to eight 32-bit keys (capacity register, reset 5,
// 0 acts as 1, above 8 acts as 8). Each key word yields one result word: hit, eviction,
// evicted key, the pushed key and the new occupancy. A key is first captured, then goes
// through the single compare-and-shift step over all entries; no new word is taken until
// that step has committed. A finished result waits in an output register while the next
// key is captured; the commit stalls only while that register is still full.
// Write capacity only while the block is idle.
module recency_list_move_to_front_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  rlmtf_pkg::key_t     key,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                hit,
	output logic                evicted,
	output rlmtf_pkg::key_t     evicted_key,
	output rlmtf_pkg::key_t     most_recent_key,
	output rlmtf_pkg::cnt_t     occupancy
);
	import rlmtf_pkg::*;

	cmd_t    cmd;
	status_t status;

	rlmtf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rlmtf_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.key             (key),
		.cmd             (cmd),
		.status          (status),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.hit             (hit),
		.evicted         (evicted),
		.evicted_key     (evicted_key),
		.most_recent_key (most_recent_key),
		.occupancy       (occupancy)
	);

endmodule
